/* rtl/core/atoi_pkg.sv */
// Package for the auto-base ASCII to integer parser.
// Holds field widths, character codes, parse phases and the digit helper.
// No dependencies; compile first.
package atoi_pkg;

  // Field widths
  localparam int CharW  = 8;
  localparam int ValueW = 64;
  localparam int OffW   = 13;
  localparam int DigitW = 4;

  // Longest string that is counted; offset saturates here
  localparam int MaxLen   = 4096;
  localparam int OffMax   = (1 << OffW) - 1;
  localparam int PosLimit = (MaxLen < OffMax) ? MaxLen : OffMax;
  localparam logic [OffW-1:0] PosLimitV = OffW'(PosLimit);

  // Character codes
  localparam logic [CharW-1:0] ChZero  = 8'h30;  // '0'
  localparam logic [CharW-1:0] ChNine  = 8'h39;  // '9'
  localparam logic [CharW-1:0] ChUpA   = 8'h41;  // 'A'
  localparam logic [CharW-1:0] ChUpF   = 8'h46;  // 'F'
  localparam logic [CharW-1:0] ChLoA   = 8'h61;  // 'a'
  localparam logic [CharW-1:0] ChLoF   = 8'h66;  // 'f'
  localparam logic [CharW-1:0] ChLoX   = 8'h78;  // 'x'
  localparam logic [CharW-1:0] ChUpX   = 8'h58;  // 'X'
  localparam logic [CharW-1:0] ChSpace = 8'h20;  // ' '
  localparam logic [CharW-1:0] ChMinus = 8'h2d;  // '-'
  localparam logic [CharW-1:0] ChPlus  = 8'h2b;  // '+'

  // Parse phases
  typedef enum logic [2:0] {
    PH_DONE,
    PH_SPACE,
    PH_SIGNED,
    PH_ZERO,
    PH_DIGITS
  } phase_t;

  // Digit decode for one character
  typedef struct packed {
    logic              ok;
    logic [DigitW-1:0] val;
  } digit_t;

  function automatic digit_t decode_digit(input logic [CharW-1:0] c, input logic hex);
    digit_t d;
    d.ok  = 1'b0;
    d.val = '0;
    if (c >= ChZero && c <= ChNine) begin
      d.ok  = 1'b1;
      d.val = c[3:0];
    end else if (hex && ((c >= ChUpA && c <= ChUpF) || (c >= ChLoA && c <= ChLoF))) begin
      // 'A'/'a' have low bits 1, so adding 9 gives 10
      d.ok  = 1'b1;
      d.val = {1'b0, c[2:0]} + DigitW'(9);
    end
    return d;
  endfunction

endpackage

/* rtl/core/atoi_if.sv */
// Valid/ready channel interfaces for the ASCII to integer parser.
// Depends on atoi_pkg for the payload widths.
interface atoi_char_if
  import atoi_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             start_req;
  logic [CharW-1:0] character;

  modport source (output valid, start_req, character, input ready);
  modport sink (input valid, start_req, character, output ready);
endinterface

interface atoi_result_if
  import atoi_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [ValueW-1:0] value;
  logic [OffW-1:0]   end_offset;

  modport source (output valid, value, end_offset, input ready);
  modport sink (input valid, value, end_offset, output ready);
endinterface

/* rtl/core/ascii_to_integer_auto_base_unit.sv */
// Streaming auto-base ASCII to integer parser, one character per transfer.
// Latency: a stopping character's result is valid the cycle after its transfer.
// Throughput: one character per cycle unless an unread result is held.
// The step logic (shift-add by 10 or 16 plus digit, then negate) sits between
// the parse state and the result register. Synchronous active-high reset puts the
// parser in the done phase (waiting for start) with narrow_to_32 cleared.
module ascii_to_integer_auto_base_unit
  import atoi_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  atoi_char_if.sink     chars,
  atoi_result_if.source results,
  input  logic          cfg_we,
  input  logic          cfg_data
);

  // Parse state
  phase_t            phase, phase_next;
  logic [ValueW-1:0] accumulator, accumulator_next;
  logic              negative_seen, negative_seen_next;
  logic              hex_mode, hex_mode_next;
  logic [OffW-1:0]   position, position_next;
  logic              narrow_to_32;

  // Result register
  logic              res_valid;
  logic [ValueW-1:0] res_value, res_value_next;
  logic [OffW-1:0]   res_offset;

  logic              accept;
  logic              emit;

  // Start-adjusted view of the state
  phase_t            ph_eff;
  logic [ValueW-1:0] acc_eff;
  logic              neg_eff;
  logic              hex_eff;
  logic [OffW-1:0]   pos_eff;
  logic [OffW-1:0]   pos_adv;
  digit_t            dig;
  logic [ValueW-1:0] acc_step;
  logic [CharW-1:0]  c;

  assign accept       = chars.valid && chars.ready;
  assign chars.ready  = !res_valid || results.ready;
  assign c            = chars.character;

  assign results.valid      = res_valid;
  assign results.value      = res_value;
  assign results.end_offset = res_offset;

  // Next state for one accepted character
  always_comb begin
    if (chars.start_req) begin
      ph_eff  = PH_SPACE;
      acc_eff = '0;
      neg_eff = 1'b0;
      hex_eff = 1'b0;
      pos_eff = '0;
    end else begin
      ph_eff  = phase;
      acc_eff = accumulator;
      neg_eff = negative_seen;
      hex_eff = hex_mode;
      pos_eff = position;
    end

    pos_adv  = (pos_eff < PosLimitV) ? pos_eff + OffW'(1) : pos_eff;
    dig      = decode_digit(c, hex_eff);
    // acc*16 or acc*10 as shifts and adds
    acc_step = hex_eff ? ({acc_eff[ValueW-5:0], 4'b0} + ValueW'(dig.val))
                       : ({acc_eff[ValueW-4:0], 3'b0} + {acc_eff[ValueW-2:0], 1'b0}
                          + ValueW'(dig.val));

    phase_next         = ph_eff;
    accumulator_next   = acc_eff;
    negative_seen_next = neg_eff;
    hex_mode_next      = hex_eff;
    position_next      = pos_eff;
    emit               = 1'b0;

    case (ph_eff)
      PH_SPACE: begin
        if (c == ChSpace) begin
          position_next = pos_adv;
        end else if (c == ChMinus || c == ChPlus) begin
          negative_seen_next = (c == ChMinus);
          position_next      = pos_adv;
          phase_next         = PH_SIGNED;
        end else if (c == ChZero) begin
          position_next = pos_adv;
          phase_next    = PH_ZERO;
        end else if (dig.ok) begin
          accumulator_next = acc_step;
          position_next    = pos_adv;
          phase_next       = PH_DIGITS;
        end else begin
          emit       = 1'b1;
          phase_next = PH_DONE;
        end
      end
      PH_SIGNED: begin
        if (c == ChZero) begin
          position_next = pos_adv;
          phase_next    = PH_ZERO;
        end else if (dig.ok) begin
          accumulator_next = acc_step;
          position_next    = pos_adv;
          phase_next       = PH_DIGITS;
        end else begin
          emit       = 1'b1;
          phase_next = PH_DONE;
        end
      end
      PH_ZERO: begin
        if (c == ChLoX || c == ChUpX) begin
          hex_mode_next = 1'b1;
          position_next = pos_adv;
          phase_next    = PH_DIGITS;
        end else if (dig.ok) begin
          accumulator_next = acc_step;
          position_next    = pos_adv;
          phase_next       = PH_DIGITS;
        end else begin
          emit       = 1'b1;
          phase_next = PH_DONE;
        end
      end
      PH_DIGITS: begin
        if (dig.ok) begin
          accumulator_next = acc_step;
          position_next    = pos_adv;
        end else begin
          emit       = 1'b1;
          phase_next = PH_DONE;
        end
      end
      default: begin
        // done: ignore characters until a start
        phase_next = PH_DONE;
      end
    endcase

    // Sign and width of the emitted value
    res_value_next = neg_eff ? (~acc_eff + ValueW'(1)) : acc_eff;
    if (narrow_to_32) begin
      res_value_next[ValueW-1:32] = '0;
    end
  end

  // Parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_DONE;
      accumulator   <= '0;
      negative_seen <= 1'b0;
      hex_mode      <= 1'b0;
      position      <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      accumulator   <= accumulator_next;
      negative_seen <= negative_seen_next;
      hex_mode      <= hex_mode_next;
      position      <= position_next;
    end
  end

  // Mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      narrow_to_32 <= 1'b0;
    end else if (cfg_we) begin
      narrow_to_32 <= cfg_data;
    end
  end

  // Result register: loads on a stopping character, clears when read
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept && emit) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      res_value  <= res_value_next;
      res_offset <= pos_eff;
    end
  end

  // Checks
  a_emit_ends_parse: assert property (@(posedge clk) disable iff (rst)
    accept && emit |=> phase == PH_DONE && res_valid)
    else $error("parse not closed after result");

  a_done_is_silent: assert property (@(posedge clk) disable iff (rst)
    accept && !chars.start_req && phase == PH_DONE |-> !emit)
    else $error("result from done phase without start");

  a_hex_only_in_digits: assert property (@(posedge clk) disable iff (rst)
    hex_mode |-> (phase == PH_DIGITS || phase == PH_DONE))
    else $error("hex mode outside digit phase");

  a_pos_saturates: assert property (@(posedge clk) disable iff (rst)
    position <= PosLimitV)
    else $error("position beyond limit");

  a_narrow_value: assert property (@(posedge clk) disable iff (rst)
    accept && emit && narrow_to_32 |=> res_value[ValueW-1:32] == '0)
    else $error("narrow result has high bits set");

endmodule
